// ----- src/idba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idba_pkg
// Shared types and constants of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package idba_pkg;

  localparam int unsigned IdW         = 16;
  localparam int unsigned MapWordsDef = 256;
  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [IdW-1:0] BaseIdRst = 16'd300;
  localparam logic [IdW-1:0] MaxIdRst  = 16'd5000;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ID = 1'b0,
    CFG_MAX_ID  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e            op;
    logic [IdW-1:0] release_id;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0] alloc_id;
    logic           failed;
  } out_item_t;

  typedef struct packed {
    logic clr_wr;
    logic start;
    logic scan_rd;
    logic scan_adv;
    logic finish;
    logic rel_mul;
    logic rel_div;
    logic rel_rd;
    logic rel_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_release;
    logic done;
    logic out_free;
    logic rel_ok;
  } dp_status_t;

endpackage

// ----- src/idba_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idba_dp
// Bitmap memory, scan word counter, first-clear-bit search, release offset
// split and the result register.
// ----------------------------------------------------------------------------
module idba_dp #(
  parameter int unsigned MAP_WORDS = idba_pkg::MapWordsDef,
  parameter int unsigned WORD_BITS = idba_pkg::WordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  idba_pkg::dp_cmd_t              cmd_i,
  output idba_pkg::dp_status_t           status_o,
  input  logic [idba_pkg::IdW-1:0]       base_i,
  input  logic [idba_pkg::IdW-1:0]       max_i,
  input  idba_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output idba_pkg::out_item_t            out_data_o
);

  localparam int unsigned IdW      = idba_pkg::IdW;
  localparam int unsigned AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW       = $clog2(WORD_BITS);
  localparam int unsigned CW       = (((AW + BW) > IdW) ? (AW + BW) : IdW) + 1;
  localparam int unsigned DivShift = IdW + BW;
  localparam int unsigned MulW     = IdW + 1;
  localparam int unsigned ProdW    = IdW + MulW;
  localparam int unsigned QW       = ProdW - DivShift;
  localparam longint unsigned DivMulL =
    ((longint'(1) << DivShift) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
  localparam logic [MulW-1:0]  DivMul    = MulW'(DivMulL);
  localparam logic [IdW-1:0]   WordBitsC = IdW'(WORD_BITS);
  localparam logic [IdW:0]     MapWordsC = (IdW + 1)'(MAP_WORDS);
  localparam logic [AW-1:0]    LastWord  = AW'(MAP_WORDS - 1);
  localparam logic [BW-1:0]    LastBit   = BW'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;

  logic [AW-1:0]  clr_cnt_q;
  logic [AW-1:0]  w_q;
  logic [CW-1:0]  cand_q;
  logic [IdW-1:0] id_q;

  logic [IdW-1:0]   off_q;
  logic             in_range_q;
  logic [ProdW-1:0] prod_q;
  logic [IdW-1:0]   q_q, r_q;
  logic             rel_ok_q;
  logic [IdW-1:0]   q_ext, off_d;

  logic            hit, over, fail, last_word;
  logic [BW-1:0]   bit_idx, idx;
  logic [CW-1:0]   cand;

  idba_pkg::out_item_t out_q;
  logic                out_valid_q;

  // first clear bit, lowest index wins
  always_comb begin
    hit     = 1'b0;
    bit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rdata_q[i]) begin
        hit     = 1'b1;
        bit_idx = BW'(i);
      end
    end
  end

  assign last_word = (w_q == LastWord);
  assign idx       = hit ? bit_idx : LastBit;
  assign cand      = cand_q + CW'(idx);
  assign over      = (cand > CW'(max_i));
  assign fail      = over || !hit;

  assign off_d = id_q - base_i;
  assign q_ext = IdW'(prod_q[DivShift +: QW]);

  assign status_o.clr_last   = (clr_cnt_q == LastWord);
  assign status_o.in_release = (in_data_i.op == idba_pkg::OP_RELEASE);
  assign status_o.done       = over || hit || last_word;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.rel_ok     = rel_ok_q;

  always_comb begin
    rd_addr = w_q;
    if (cmd_i.scan_adv) begin
      rd_addr = w_q + AW'(1);
    end else if (cmd_i.rel_rd) begin
      rd_addr = q_q[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd_i.clr_wr || (cmd_i.finish && !fail) || cmd_i.rel_wr;
    wr_addr = w_q;
    wr_data = rdata_q | (WORD_BITS'(1) << bit_idx);
    if (cmd_i.clr_wr) begin
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (cmd_i.rel_wr) begin
      wr_addr = q_q[AW-1:0];
      wr_data = rdata_q & ~(WORD_BITS'(1) << r_q[BW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q    <= '0;
      cand_q <= CW'(base_i);
      id_q   <= in_data_i.release_id;
    end else if (cmd_i.scan_adv) begin
      w_q    <= w_q + AW'(1);
      cand_q <= cand_q + CW'(WORD_BITS);
    end
  end

  // release offset split into word and bit by reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.rel_mul) begin
      off_q      <= off_d;
      in_range_q <= (id_q >= base_i) && (id_q <= max_i);
      prod_q     <= ProdW'(off_d) * ProdW'(DivMul);
    end
    if (cmd_i.rel_div) begin
      q_q      <= q_ext;
      r_q      <= off_q - IdW'(q_ext * WordBitsC);
      rel_ok_q <= in_range_q && ({1'b0, q_ext} < MapWordsC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.alloc_id <= fail ? '0 : cand[IdW-1:0];
      out_q.failed   <= fail;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.finish)
    else $error("result register loaded while a result is still held");

  a_scan_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_adv |-> !last_word)
    else $error("scan advanced past the last bitmap word");

  a_bit_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rel_rd |-> (r_q < WordBitsC))
    else $error("release bit index out of word");

endmodule

// ----- src/idba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idba_ctrl
// Sequencer: clearing pass, allocate scan and release read-modify-write.
// ----------------------------------------------------------------------------
module idba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  idba_pkg::dp_status_t status_i,
  output idba_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_A_RD  = 8'b0000_0100,
    ST_A_CHK = 8'b0000_1000,
    ST_R_MUL = 8'b0001_0000,
    ST_R_DIV = 8'b0010_0000,
    ST_R_RD  = 8'b0100_0000,
    ST_R_WR  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.in_release ? ST_R_MUL : ST_A_RD;
        end
      end
      ST_A_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (!status_i.done) begin
          cmd_o.scan_adv = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_R_MUL: begin
        cmd_o.rel_mul = 1'b1;
        state_d       = ST_R_DIV;
      end
      ST_R_DIV: begin
        cmd_o.rel_div = 1'b1;
        state_d       = ST_R_RD;
      end
      ST_R_RD: begin
        if (status_i.rel_ok) begin
          cmd_o.rel_rd = 1'b1;
          state_d      = ST_R_WR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_R_WR: begin
        cmd_o.rel_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_release_write_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_R_WR) |-> $past(state_q == ST_R_RD && status_i.rel_ok))
    else $error("bitmap release write without an in-range identifier");

endmodule

// ----- src/id_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_bitmap_allocator
// First-free identifier allocator over an in-use bitmap held in a RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAP_WORDS words (256 by default) of the
// bitmap RAM to zero, one word per cycle, with in_stall_o high; configuration
// writes are taken throughout. An allocate examines 1 to MAP_WORDS bitmap
// words, the single RAM read port delivering one word per cycle to the
// first-clear-bit search, and finishes only once the output register is free.
// A release runs the offset split, a word read and a word write; the read and
// write are skipped when the identifier is out of range. Only allocates return
// a transfer; a finished result waits in an output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
module id_bitmap_allocator #(
  parameter int unsigned MAP_WORDS = idba_pkg::MapWordsDef,
  parameter int unsigned WORD_BITS = idba_pkg::WordBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  idba_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output idba_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [idba_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [idba_pkg::IdW-1:0]         cfg_data_i
);

  logic [idba_pkg::IdW-1:0] base_q, max_q;
  idba_pkg::dp_cmd_t        cmd;
  idba_pkg::dp_status_t     status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= idba_pkg::BaseIdRst;
      max_q  <= idba_pkg::MaxIdRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (idba_pkg::cfg_idx_e'(cfg_index_i))
        idba_pkg::CFG_BASE_ID: base_q <= cfg_data_i;
        idba_pkg::CFG_MAX_ID:  max_q  <= cfg_data_i;
      endcase
    end
  end

  idba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  idba_dp #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .base_i      (base_q),
    .max_i       (max_q),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
